>>> design/sdrq_pkg.sv
package sdrq_pkg;

   // Field widths of the request and response transactions.
   localparam int FUNC_W         = 1;
   localparam int PROC_ID_W      = 16;
   localparam int TIME_W         = 32;
   localparam int ENTRY_COUNT_W  = 7;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORDER_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EMPTY_TIME = 1'b1;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 1'b1;

   // Ordering modes.
   localparam logic MODE_READY   = 1'b0;
   localparam logic MODE_WAITING = 1'b1;

   // Reset values.
   localparam logic [31:0] RESET_EMPTY_TIME = 32'd1000000;
   localparam logic [31:0] RESET_NEXT_TIME  = 32'd100000000;

   // Parameter defaults.
   localparam int DEFAULT_QUEUE_DEPTH = 64;
   localparam int DEFAULT_PID_BITS    = 16;
   localparam int DEFAULT_TIME_BITS   = 32;

endpackage

>>> design/sdrq_req_if.sv
interface sdrq_req_if;

   logic                              valid;
   logic                              ready;
   logic [sdrq_pkg::FUNC_W-1:0]       func;
   logic [sdrq_pkg::PROC_ID_W-1:0]    proc_id;
   logic [sdrq_pkg::TIME_W-1:0]       due_time;
   logic [sdrq_pkg::TIME_W-1:0]       release_time;

   modport source (output valid, func, proc_id, due_time, release_time, input ready);
   modport sink   (input valid, func, proc_id, due_time, release_time, output ready);

endinterface

>>> design/sdrq_rsp_if.sv
interface sdrq_rsp_if;

   logic                                 valid;
   logic                                 ready;
   logic                                 op_ok;
   logic [sdrq_pkg::PROC_ID_W-1:0]       out_proc_id;
   logic [sdrq_pkg::TIME_W-1:0]          out_due_time;
   logic [sdrq_pkg::TIME_W-1:0]          out_release_time;
   logic [sdrq_pkg::ENTRY_COUNT_W-1:0]   entry_count;
   logic [sdrq_pkg::TIME_W-1:0]          next_event_time;

   modport source (output valid, op_ok, out_proc_id, out_due_time, out_release_time,
                   entry_count, next_event_time, input ready);
   modport sink   (input valid, op_ok, out_proc_id, out_due_time, out_release_time,
                   entry_count, next_event_time, output ready);

endinterface

>>> design/sdrq_mem.sv
module sdrq_mem #(
   parameter int DEPTH = sdrq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int WIDTH = sdrq_pkg::DEFAULT_PID_BITS + 2 * sdrq_pkg::DEFAULT_TIME_BITS
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // One read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sdrq_key_cmp.sv
module sdrq_key_cmp #(
   parameter int PID_BITS  = sdrq_pkg::DEFAULT_PID_BITS,
   parameter int TIME_BITS = sdrq_pkg::DEFAULT_TIME_BITS
) (
   input  logic                 order_mode,
   input  logic [PID_BITS-1:0]  slot_pid,
   input  logic [TIME_BITS-1:0] slot_due,
   input  logic [TIME_BITS-1:0] slot_start,
   input  logic [PID_BITS-1:0]  new_pid,
   input  logic [TIME_BITS-1:0] new_due,
   input  logic [TIME_BITS-1:0] new_start,
   output logic                 slot_after
);

   // The held key is strictly greater than the new key, compared
   // lexicographically; the start time leads only in waiting mode.
   always_comb begin
      if (order_mode == sdrq_pkg::MODE_WAITING && slot_start != new_start) begin
         slot_after = slot_start > new_start;
      end else if (slot_due != new_due) begin
         slot_after = slot_due > new_due;
      end else begin
         slot_after = slot_pid > new_pid;
      end
   end

endmodule

>>> design/sorted_deadline_ready_queue.sv
// Sorted deadline ready queue.
// The request channel carries one operation per transaction: insert an entry
// (pid, deadline, start time) at its place in key order, or pop the head.
// Every request gives exactly one response transaction with a success flag,
// the popped entry (zero otherwise), the entry count and the next event time.
// Entries sit in one single-port-write, single-port-read memory used as a
// ring; a pop only reads the head and advances the ring start.
// A pop reads the head and then takes it out; a refused operation or an insert
// into an empty queue goes straight to the final stage; an insert into a
// non-empty queue walks the ring and then writes the tail slot. The insert walks
// the ring from the head, at most one memory read and one write each cycle,
// comparing each entry and pushing the displaced tail one slot back.
// A new request is taken the cycle after the previous operation reaches the
// output register; no request is taken while one is in work.
// A response that the receiver stalls stays in the output register; the next
// request is still accepted and worked, and holds in the final stage until the
// output register frees.
// Reset clears the count, loads the next event time with 100000000 and the
// configuration with ready mode and empty time 1000000. Memory contents need
// no clearing, as only entries below the count are ever read.
module sorted_deadline_ready_queue #(
   parameter int QUEUE_DEPTH = sdrq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int PID_BITS    = sdrq_pkg::DEFAULT_PID_BITS,
   parameter int TIME_BITS   = sdrq_pkg::DEFAULT_TIME_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sdrq_req_if.sink                             req_if,
   sdrq_rsp_if.source                           rsp_if,
   input  logic                                 csr_we,
   input  logic [sdrq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sdrq_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = PID_BITS + 2 * TIME_BITS;
   localparam logic [IDX_W:0]   DEPTH_W = (IDX_W + 1)'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_INS_RUN  = 5'b00010,
      ST_INS_TAIL = 5'b00100,
      ST_POP      = 5'b01000,
      ST_DONE     = 5'b10000
   } state_type;

   // Physical memory slot of a position counted from the head.
   function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] base,
                                                   input logic [IDX_W-1:0] offs);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   found_ff, found_in;
   logic                   head_hit_ff, head_hit_in;
   logic [ENTRY_W-1:0]     carry_ff, carry_in;
   logic [TIME_BITS-1:0]   next_time_ff, next_time_in;
   logic                   order_mode_ff, order_mode_in;
   logic [TIME_BITS-1:0]   empty_time_ff, empty_time_in;

   logic [PID_BITS-1:0]    new_pid_ff, new_pid_in;
   logic [TIME_BITS-1:0]   new_due_ff, new_due_in;
   logic [TIME_BITS-1:0]   new_start_ff, new_start_in;

   logic                   pend_ok_ff, pend_ok_in;
   logic [PID_BITS-1:0]    pend_pid_ff, pend_pid_in;
   logic [TIME_BITS-1:0]   pend_due_ff, pend_due_in;
   logic [TIME_BITS-1:0]   pend_start_ff, pend_start_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_ok_ff, rsp_ok_in;
   logic [sdrq_pkg::PROC_ID_W-1:0]         rsp_pid_ff, rsp_pid_in;
   logic [sdrq_pkg::TIME_W-1:0]            rsp_due_ff, rsp_due_in;
   logic [sdrq_pkg::TIME_W-1:0]            rsp_start_ff, rsp_start_in;
   logic [sdrq_pkg::ENTRY_COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [sdrq_pkg::TIME_W-1:0]            rsp_next_ff, rsp_next_in;

   logic                   mem_wr_en;
   logic [IDX_W-1:0]       mem_wr_addr;
   logic [ENTRY_W-1:0]     mem_wr_data;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;
   logic [ENTRY_W-1:0]     mem_rd_data;

   logic                   req_take;
   logic                   can_emit;
   logic                   last_slot;
   logic                   slot_after;
   logic [ENTRY_W-1:0]     new_entry;
   logic [PID_BITS-1:0]    req_pid;
   logic [TIME_BITS-1:0]   req_due;
   logic [TIME_BITS-1:0]   req_start;

   // Entry storage.
   sdrq_mem #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Key comparison of the entry just read against the entry being inserted.
   sdrq_key_cmp #(
      .PID_BITS  (PID_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_key_cmp (
      .order_mode (order_mode_ff),
      .slot_pid   (mem_rd_data[PID_BITS-1:0]),
      .slot_due   (mem_rd_data[PID_BITS +: TIME_BITS]),
      .slot_start (mem_rd_data[PID_BITS + TIME_BITS +: TIME_BITS]),
      .new_pid    (new_pid_ff),
      .new_due    (new_due_ff),
      .new_start  (new_start_ff),
      .slot_after (slot_after)
   );

   // Handshake and helper terms.
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign can_emit     = !rsp_valid_ff || rsp_if.ready;
   assign last_slot    = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign new_entry    = {new_start_ff, new_due_ff, new_pid_ff};
   assign req_pid      = PID_BITS'(req_if.proc_id);
   assign req_due      = TIME_BITS'(req_if.due_time);
   assign req_start    = TIME_BITS'(req_if.release_time);

   // Operation sequencer.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      head_hit_in   = head_hit_ff;
      carry_in      = carry_ff;
      next_time_in  = next_time_ff;
      new_pid_in    = new_pid_ff;
      new_due_in    = new_due_ff;
      new_start_in  = new_start_ff;
      pend_ok_in    = pend_ok_ff;
      pend_pid_in   = pend_pid_ff;
      pend_due_in   = pend_due_ff;
      pend_start_in = pend_start_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = head_ff;
      mem_wr_data   = new_entry;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               new_pid_in    = req_pid;
               new_due_in    = req_due;
               new_start_in  = req_start;
               pend_ok_in    = 1'b0;
               pend_pid_in   = '0;
               pend_due_in   = '0;
               pend_start_in = '0;
               if (req_if.func == sdrq_pkg::FUNC_INSERT) begin
                  if (count_ff == FULL_COUNT) begin
                     state_in = ST_DONE;
                  end else if (count_ff == '0) begin
                     // Empty queue: the new entry becomes the head at once.
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = head_ff;
                     mem_wr_data = {req_start, req_due, req_pid};
                     count_in    = CNT_W'(1);
                     if (order_mode_ff == sdrq_pkg::MODE_WAITING) begin
                        next_time_in = req_start;
                     end
                     pend_ok_in = 1'b1;
                     state_in   = ST_DONE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = head_ff;
                     idx_in      = '0;
                     found_in    = 1'b0;
                     head_hit_in = 1'b0;
                     state_in    = ST_INS_RUN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = head_ff;
                     state_in    = ST_POP;
                  end
               end
            end
         end

         ST_INS_RUN: begin
            // Before the insert point nothing moves; from there on each
            // slot takes the entry that stood one place ahead of it.
            mem_wr_addr = slot_addr(head_ff, idx_ff);
            if (found_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = carry_ff;
               carry_in    = mem_rd_data;
            end else if (slot_after) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = new_entry;
               carry_in    = mem_rd_data;
               found_in    = 1'b1;
               head_hit_in = (idx_ff == '0);
            end
            if (last_slot) begin
               state_in = ST_INS_TAIL;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot_addr(head_ff, idx_ff + IDX_W'(1));
               idx_in      = idx_ff + IDX_W'(1);
            end
         end

         ST_INS_TAIL: begin
            // The last displaced entry, or the new one if nothing was greater.
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot_addr(head_ff, count_ff[IDX_W-1:0]);
            mem_wr_data = found_ff ? carry_ff : new_entry;
            count_in    = count_ff + CNT_W'(1);
            if (order_mode_ff == sdrq_pkg::MODE_WAITING && head_hit_ff) begin
               next_time_in = new_start_ff;
            end
            pend_ok_in = 1'b1;
            state_in   = ST_DONE;
         end

         ST_POP: begin
            pend_pid_in   = mem_rd_data[PID_BITS-1:0];
            pend_due_in   = mem_rd_data[PID_BITS +: TIME_BITS];
            pend_start_in = mem_rd_data[PID_BITS + TIME_BITS +: TIME_BITS];
            head_in       = slot_addr(head_ff, IDX_W'(1));
            count_in      = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               next_time_in = empty_time_ff;
            end
            pend_ok_in = 1'b1;
            state_in   = ST_DONE;
         end

         ST_DONE: begin
            if (can_emit) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loaded from the finished operation, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_pid_in   = rsp_pid_ff;
      rsp_due_in   = rsp_due_ff;
      rsp_start_in = rsp_start_ff;
      rsp_count_in = rsp_count_ff;
      rsp_next_in  = rsp_next_ff;
      if (state_ff == ST_DONE && can_emit) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = pend_ok_ff;
         rsp_pid_in   = sdrq_pkg::PROC_ID_W'(pend_pid_ff);
         rsp_due_in   = sdrq_pkg::TIME_W'(pend_due_ff);
         rsp_start_in = sdrq_pkg::TIME_W'(pend_start_ff);
         rsp_count_in = sdrq_pkg::ENTRY_COUNT_W'(count_ff);
         rsp_next_in  = sdrq_pkg::TIME_W'(next_time_ff);
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration writes.
   always_comb begin
      order_mode_in = order_mode_ff;
      empty_time_in = empty_time_ff;
      if (csr_we) begin
         case (csr_index)
            sdrq_pkg::CSR_ORDER_MODE: order_mode_in = csr_wdata[0];
            sdrq_pkg::CSR_EMPTY_TIME: empty_time_in = TIME_BITS'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         head_ff       <= '0;
         next_time_ff  <= TIME_BITS'(sdrq_pkg::RESET_NEXT_TIME);
         order_mode_ff <= sdrq_pkg::MODE_READY;
         empty_time_ff <= TIME_BITS'(sdrq_pkg::RESET_EMPTY_TIME);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         next_time_ff  <= next_time_in;
         order_mode_ff <= order_mode_in;
         empty_time_ff <= empty_time_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      head_hit_ff   <= head_hit_in;
      carry_ff      <= carry_in;
      new_pid_ff    <= new_pid_in;
      new_due_ff    <= new_due_in;
      new_start_ff  <= new_start_in;
      pend_ok_ff    <= pend_ok_in;
      pend_pid_ff   <= pend_pid_in;
      pend_due_ff   <= pend_due_in;
      pend_start_ff <= pend_start_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_due_ff    <= rsp_due_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_next_ff   <= rsp_next_in;
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.op_ok            = rsp_ok_ff;
   assign rsp_if.out_proc_id      = rsp_pid_ff;
   assign rsp_if.out_due_time     = rsp_due_ff;
   assign rsp_if.out_release_time = rsp_start_ff;
   assign rsp_if.entry_count      = rsp_count_ff;
   assign rsp_if.next_event_time  = rsp_next_ff;

   // The count never exceeds the memory depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond queue depth");

   // A read and a write in the same cycle never hit the same slot.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("memory read and write collide on one slot");

   // The insert walk stays inside the held entries.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_RUN) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("insert walk index past the held entries");

   // A pop removes exactly one entry.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |=> (count_ff + CNT_W'(1) == $past(count_ff)))
      else $error("pop did not remove exactly one entry");

   // A response appears only out of the final stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the final stage");

endmodule

>>> tb/sorted_deadline_ready_queue_tb.sv
module sorted_deadline_ready_queue_tb;

   import sdrq_pkg::*;

   localparam int QDEPTH       = DEFAULT_QUEUE_DEPTH;
   localparam int DRAIN_CYCLES = 80;
   localparam int EPISODE_LEN  = 80;

   // One request: the operation and the entry it carries.
   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [PROC_ID_W-1:0] pid;
      logic [TIME_W-1:0]    dl;
      logic [TIME_W-1:0]    st;
   } sched_op_t;

   // One entry held in the queue.
   typedef struct packed {
      logic [PROC_ID_W-1:0] pid;
      logic [TIME_W-1:0]    dl;
      logic [TIME_W-1:0]    st;
   } sched_entry_t;

   // One response, field for field as the block reports it.
   typedef struct packed {
      logic                     ok;
      logic [PROC_ID_W-1:0]     pid;
      logic [TIME_W-1:0]        dl;
      logic [TIME_W-1:0]        st;
      logic [ENTRY_COUNT_W-1:0] count;
      logic [TIME_W-1:0]        next_time;
   } sched_result_t;

   typedef enum {ROW_OP, ROW_CSR} row_kind_e;

   typedef struct {
      row_kind_e              kind;
      sched_op_t              op;
      logic [CSR_INDEX_W-1:0] reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
      bit                     typed;
      sched_result_t          want;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sdrq_req_if req_ch ();
   sdrq_rsp_if rsp_ch ();

   sorted_deadline_ready_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the queue contents, the registers and the next event time.
   sched_entry_t     held[$];
   logic             mode_now  = MODE_READY;
   logic [TIME_W-1:0] empty_now = RESET_EMPTY_TIME;
   logic [TIME_W-1:0] next_now  = RESET_NEXT_TIME;

   // Responses still owed by the block, oldest first.
   sched_result_t sched_results_due[$];

   int mismatches = 0;
   int n_ins = 0;
   int n_pop = 0;
   int n_full = 0;
   int n_empty = 0;
   int peak_held = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;

   stim_row_t directed_rows[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // True when a held entry sorts strictly behind a new one under the current mode.
   function automatic bit ranks_after(sched_entry_t h, sched_entry_t n);
      if (mode_now == MODE_WAITING && h.st != n.st) return h.st > n.st;
      if (h.dl != n.dl) return h.dl > n.dl;
      return h.pid > n.pid;
   endfunction

   // Applies one operation to the shadow queue and returns the response it gives.
   function automatic sched_result_t run_sched_op(sched_op_t o);
      sched_result_t r;
      sched_entry_t  e;
      int            slot;
      r = '0;
      e = '{pid: o.pid, dl: o.dl, st: o.st};
      if (o.func == FUNC_INSERT) begin
         if (held.size() < QDEPTH) begin
            slot = held.size();
            for (int i = 0; i < held.size(); i++) begin
               if (ranks_after(held[i], e)) begin
                  slot = i;
                  break;
               end
            end
            held.insert(slot, e);
            if (mode_now == MODE_WAITING && slot == 0) next_now = o.st;
            r.ok = 1'b1;
         end
      end else if (held.size() > 0) begin
         e = held.pop_front();
         r.pid = e.pid;
         r.dl  = e.dl;
         r.st  = e.st;
         if (held.size() == 0) next_now = empty_now;
         r.ok = 1'b1;
      end
      r.count     = ENTRY_COUNT_W'(held.size());
      r.next_time = next_now;
      return r;
   endfunction

   // Times are drawn from a tiny range half the time so that keys tie often.
   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(9))
         0, 1, 2, 3: return TIME_W'($urandom_range(7));
         4:          return 32'hFFFF_FFFF - TIME_W'($urandom_range(3));
         5:          return '0;
         6:          return TIME_W'($urandom_range(200000));
         default:    return TIME_W'($urandom());
      endcase
   endfunction

   function automatic logic [PROC_ID_W-1:0] pick_pid();
      case ($urandom_range(5))
         0, 1, 2: return PROC_ID_W'($urandom_range(3));
         3:       return 16'hFFFF;
         default: return PROC_ID_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic sched_op_t random_op(int insert_pct);
      sched_op_t o;
      o.func = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_POP;
      o.pid  = pick_pid();
      o.dl   = pick_time();
      o.st   = pick_time();
      return o;
   endfunction

   function automatic stim_row_t op_row(logic [FUNC_W-1:0] f, logic [PROC_ID_W-1:0] pid,
                                        logic [TIME_W-1:0] dl, logic [TIME_W-1:0] st);
      stim_row_t r;
      r.kind    = ROW_OP;
      r.op      = '{func: f, pid: pid, dl: dl, st: st};
      r.reg_idx = '0;
      r.reg_val = '0;
      r.typed   = 1'b0;
      r.want    = '0;
      return r;
   endfunction

   function automatic stim_row_t typed_row(logic [FUNC_W-1:0] f, logic [PROC_ID_W-1:0] pid,
                                           logic [TIME_W-1:0] dl, logic [TIME_W-1:0] st,
                                           sched_result_t w);
      stim_row_t r;
      r       = op_row(f, pid, dl, st);
      r.typed = 1'b1;
      r.want  = w;
      return r;
   endfunction

   function automatic stim_row_t csr_row(logic [CSR_INDEX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] val);
      stim_row_t r;
      r         = op_row(FUNC_POP, '0, '0, '0);
      r.kind    = ROW_CSR;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   // Sends one request transaction and records what it must produce.
   task automatic put_op(sched_op_t o, bit typed, sched_result_t want);
      sched_result_t r;
      int            gap;
      gap = 0;
      while ($urandom_range(99) < req_gap_pct) gap++;
      csr_we <= 1'b0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= o.func;
      req_ch.proc_id      <= o.pid;
      req_ch.due_time     <= o.dl;
      req_ch.release_time <= o.st;
      do @(posedge clock); while (!req_ch.ready);
      r = run_sched_op(o);
      sched_results_due.push_back(typed ? want : r);
      if (o.func == FUNC_INSERT) n_ins++;
      else n_pop++;
      if (!r.ok && o.func == FUNC_INSERT) n_full++;
      if (!r.ok && o.func == FUNC_POP) n_empty++;
      if (held.size() > peak_held) peak_held = held.size();
   endtask

   // Writes one register once every owed response has come back.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_ch.valid <= 1'b0;
      while (sched_results_due.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_ORDER_MODE) mode_now = val[0];
      else empty_now = val;
   endtask

   // The receiver stalls at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compares each accepted response with the oldest owed one.
   always @(posedge clock) begin : rsp_check
      sched_result_t got;
      sched_result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{ok: rsp_ch.op_ok, pid: rsp_ch.out_proc_id, dl: rsp_ch.out_due_time,
                 st: rsp_ch.out_release_time, count: rsp_ch.entry_count,
                 next_time: rsp_ch.next_event_time};
         if (sched_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response transaction with none outstanding, pid %h count %0d",
                        $time, got.pid, got.count);
         end else begin
            want = sched_results_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: expected ok=%b pid=%h dl=%h st=%h count=%0d next=%h",
                           $time, want.ok, want.pid, want.dl, want.st, want.count,
                           want.next_time);
                  $display("%0t: actual   ok=%b pid=%h dl=%h st=%h count=%0d next=%h",
                           $time, got.ok, got.pid, got.dl, got.st, got.count,
                           got.next_time);
               end
            end
         end
      end
   end

   initial begin : main
      int insert_pct[3];
      logic [CSR_DATA_W-1:0] empty_val;
      insert_pct = '{92, 50, 8};

      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_INSERT;
      req_ch.proc_id      = '0;
      req_ch.due_time     = '0;
      req_ch.release_time = '0;
      rsp_ch.ready        = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_ORDER_MODE;
      csr_wdata           = '0;

      // Directed rows. Ready mode first: errors, extremes, ties, emptying pop.
      directed_rows.push_back(typed_row(FUNC_POP, 16'h0, 32'h0, 32'h0,
         '{ok: 1'b0, count: '0, next_time: RESET_NEXT_TIME, default: '0}));
      directed_rows.push_back(typed_row(FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         '{ok: 1'b1, count: 7'd1, next_time: RESET_NEXT_TIME, default: '0}));
      directed_rows.push_back(typed_row(FUNC_INSERT, 16'h0, 32'h0, 32'h0,
         '{ok: 1'b1, count: 7'd2, next_time: RESET_NEXT_TIME, default: '0}));
      directed_rows.push_back(op_row(FUNC_INSERT, 16'd5, 32'd10, 32'd7));
      directed_rows.push_back(op_row(FUNC_INSERT, 16'd5, 32'd10, 32'd3));
      directed_rows.push_back(op_row(FUNC_INSERT, 16'd4, 32'd10, 32'd9));
      repeat (4) directed_rows.push_back(op_row(FUNC_POP, 16'h0, 32'h0, 32'h0));
      directed_rows.push_back(typed_row(FUNC_POP, 16'h0, 32'h0, 32'h0,
         '{ok: 1'b1, pid: 16'hFFFF, dl: 32'hFFFF_FFFF, st: 32'hFFFF_FFFF, count: '0,
           next_time: RESET_EMPTY_TIME}));
      directed_rows.push_back(typed_row(FUNC_POP, 16'h0, 32'h0, 32'h0,
         '{ok: 1'b0, count: '0, next_time: RESET_EMPTY_TIME, default: '0}));
      // Waiting mode: the head's start time drives the next event time.
      directed_rows.push_back(csr_row(CSR_ORDER_MODE, 32'(MODE_WAITING)));
      directed_rows.push_back(csr_row(CSR_EMPTY_TIME, 32'hFFFF_FFFF));
      directed_rows.push_back(op_row(FUNC_INSERT, 16'd1, 32'd50, 32'd20));
      directed_rows.push_back(op_row(FUNC_INSERT, 16'd2, 32'd10, 32'd30));
      directed_rows.push_back(op_row(FUNC_INSERT, 16'd3, 32'd99, 32'd20));
      directed_rows.push_back(op_row(FUNC_INSERT, 16'd9, 32'd5, 32'd0));
      // Switch back to ready mode with entries held; their order stays.
      directed_rows.push_back(csr_row(CSR_ORDER_MODE, 32'(MODE_READY)));
      directed_rows.push_back(op_row(FUNC_INSERT, 16'd7, 32'd40, 32'd0));
      repeat (5) directed_rows.push_back(op_row(FUNC_POP, 16'h0, 32'h0, 32'h0));
      directed_rows.push_back(typed_row(FUNC_POP, 16'h0, 32'h0, 32'h0,
         '{ok: 1'b0, count: '0, next_time: 32'hFFFF_FFFF, default: '0}));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      req_gap_pct   = 16;
      rsp_stall_pct = 70;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_csr(directed_rows[i].reg_idx, directed_rows[i].reg_val);
         else
            put_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random episodes that fill, churn and drain the queue under each idling profile.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_gap_pct   = 16;
               rsp_stall_pct = 70;
            end
            1: begin
               req_gap_pct   = 70;
               rsp_stall_pct = 16;
            end
            default: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int ep = 0; ep < 6; ep++) begin
            case ((phase * 6 + ep) % 4)
               0:       empty_val = 32'h0;
               1:       empty_val = 32'hFFFF_FFFF;
               2:       empty_val = RESET_EMPTY_TIME;
               default: empty_val = $urandom();
            endcase
            write_csr(CSR_ORDER_MODE, ((ep + phase) % 2 != 0) ? 32'(MODE_WAITING)
                                                               : 32'(MODE_READY));
            write_csr(CSR_EMPTY_TIME, empty_val);
            for (int k = 0; k < EPISODE_LEN; k++)
               put_op(random_op(insert_pct[ep % 3]), 1'b0, '0);
         end
      end

      // Let every owed response drain, then watch for stragglers.
      req_ch.valid <= 1'b0;
      csr_we       <= 1'b0;
      while (sched_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d inserts and %0d pops in both ordering modes, peak depth %0d of %0d.",
               n_ins, n_pop, peak_held, QDEPTH);
      $display("Refused %0d inserts into a full queue and %0d pops from an empty one.",
               n_full, n_empty);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatching response transactions.", mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Timed out with %0d responses outstanding.", sched_results_due.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
